// File: rtl/point_pair_angle_degrees_core_assert.svh
// Assertion macros shared by the point pair angle pipeline.
`ifndef POINT_PAIR_ANGLE_DEGREES_CORE_ASSERT_SVH
`define POINT_PAIR_ANGLE_DEGREES_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define PPAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define PPAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PPAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/ppad_pkg.sv
// Shared constants, angle table and pipeline types for the point pair angle core.
package ppad_pkg;

    // Field and format sizes
    localparam int COORD_WIDTH     = 16;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int CORDIC_STAGES   = 16;
    localparam int GUARD_BITS      = 8;
    localparam int TAB_FRAC        = 24;
    localparam int TAB_LEN         = 24;

    localparam int NSTAGE      = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int MAG_W       = COORD_WIDTH;
    localparam int XY_W        = COORD_WIDTH + GUARD_BITS + 3;
    localparam int Z_W         = 32;
    localparam int AF_W        = ANGLE_FRAC_BITS + 10;
    localparam int ANGLE_W     = 16;
    localparam int IN_FIELDS_W = 4 * COORD_WIDTH;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int RND_SHIFT   = TAB_FRAC - ANGLE_FRAC_BITS;

    // Angle constants
    localparam logic [Z_W-1:0]  Z_TOP      = Z_W'(64'd90 << TAB_FRAC);
    localparam logic [Z_W-1:0]  Z_HALF     = Z_W'(64'd1 << (RND_SHIFT - 1));
    localparam logic [AF_W-1:0] DEG0_Q     = '0;
    localparam logic [AF_W-1:0] DEG90_Q    = AF_W'(64'd90 << ANGLE_FRAC_BITS);
    localparam logic [AF_W-1:0] DEG180_Q   = AF_W'(64'd180 << ANGLE_FRAC_BITS);
    localparam logic [AF_W-1:0] DEG270_Q   = AF_W'(64'd270 << ANGLE_FRAC_BITS);
    localparam logic [AF_W-1:0] DEG360_Q   = AF_W'(64'd360 << ANGLE_FRAC_BITS);

    // atan(2^-i) in degrees scaled by 2^24
    localparam logic signed [Z_W-1:0] ATAN_TAB [TAB_LEN] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115
    };

    // Vectoring state of one item
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    // Per-item sideband: quadrant base or exact axis angle
    typedef struct packed {
        logic            special;
        logic            coin;
        logic [AF_W-1:0] base;
    } side_t;

endpackage

// File: rtl/ppad_front.sv
// Front end: coordinate differences, quadrant decode and vectoring seed.
`include "point_pair_angle_degrees_core_assert.svh"
module ppad_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ppad_pkg::IN_TDATA_W-1:0]  in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output ppad_pkg::cordic_t                out_vec,
    output ppad_pkg::side_t                  out_side
);
    import ppad_pkg::*;

    logic signed [COORD_WIDTH-1:0] fx, fy, tx, ty;
    logic signed [DIFF_W-1:0]      dx_next, dy_next;
    logic signed [DIFF_W-1:0]      dx_reg, dy_reg;
    logic                          a_vld_reg, b_vld_reg;
    logic                          a_rdy, b_rdy;
    logic signed [DIFF_W-1:0]      h_full, v_full;
    logic [MAG_W-1:0]              h, v, den, num;
    cordic_t                       vec_next, vec_reg;
    side_t                         side_next, side_reg;

    // Stall chain
    assign b_rdy    = !b_vld_reg || out_ready;
    assign a_rdy    = !a_vld_reg || b_rdy;
    assign in_ready = a_rdy;

    // Unpack and subtract
    assign fx      = in_data[COORD_WIDTH-1:0];
    assign fy      = in_data[2*COORD_WIDTH-1:COORD_WIDTH];
    assign tx      = in_data[3*COORD_WIDTH-1:2*COORD_WIDTH];
    assign ty      = in_data[4*COORD_WIDTH-1:3*COORD_WIDTH];
    assign dx_next = DIFF_W'(tx) - DIFF_W'(fx);
    assign dy_next = DIFF_W'(ty) - DIFF_W'(fy);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (a_rdy) begin
            a_vld_reg <= in_valid;
        end
        if (a_rdy && in_valid) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    // Decode quadrant, pick ratio operands and base angle
    assign h_full = dx_reg[DIFF_W-1] ? -dx_reg : dx_reg;
    assign v_full = dy_reg[DIFF_W-1] ? -dy_reg : dy_reg;
    assign h      = h_full[MAG_W-1:0];
    assign v      = v_full[MAG_W-1:0];

    always_comb begin
        side_next.special = 1'b0;
        side_next.coin    = 1'b0;
        side_next.base    = DEG0_Q;
        den               = h;
        num               = v;
        if (dx_reg == '0 && dy_reg == '0) begin
            side_next.special = 1'b1;
            side_next.coin    = 1'b1;
        end else if (dy_reg == '0) begin
            side_next.special = 1'b1;
            side_next.base    = dx_reg[DIFF_W-1] ? DEG180_Q : DEG360_Q;
        end else if (dx_reg == '0) begin
            side_next.special = 1'b1;
            side_next.base    = dy_reg[DIFF_W-1] ? DEG90_Q : DEG270_Q;
        end else if (!dx_reg[DIFF_W-1] && dy_reg[DIFF_W-1]) begin
            side_next.base = DEG0_Q;
        end else if (dx_reg[DIFF_W-1] && dy_reg[DIFF_W-1]) begin
            side_next.base = DEG90_Q;
            den            = v;
            num            = h;
        end else if (dx_reg[DIFF_W-1]) begin
            side_next.base = DEG180_Q;
        end else begin
            side_next.base = DEG270_Q;
            den            = v;
            num            = h;
        end
        vec_next.x = XY_W'({den, {GUARD_BITS{1'b0}}});
        vec_next.y = XY_W'({num, {GUARD_BITS{1'b0}}});
        vec_next.z = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (b_rdy) begin
            b_vld_reg <= a_vld_reg;
        end
        if (b_rdy && a_vld_reg) begin
            vec_reg  <= vec_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = b_vld_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

    `PPAD_ASSERT_NXT(a_capture, aclk, aresetn, in_valid && in_ready, a_vld_reg, "front: accepted transaction not captured")
    `PPAD_ASSERT_IMP(a_seed_pos, aclk, aresetn, b_vld_reg && !side_reg.special, vec_reg.x > 0 && vec_reg.y > 0, "front: vectoring seed not in first quadrant")
    `PPAD_ASSERT_IMP(a_coin_base, aclk, aresetn, b_vld_reg && side_reg.coin, side_reg.special && side_reg.base == DEG0_Q, "front: coincident item without zero base")

endmodule

// File: rtl/ppad_cordic.sv
// Unrolled CORDIC vectoring pipeline, one micro-rotation per register stage.
`include "point_pair_angle_degrees_core_assert.svh"
module ppad_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  ppad_pkg::cordic_t  in_vec,
    input  ppad_pkg::side_t    in_side,
    output logic               out_valid,
    input  logic               out_ready,
    output ppad_pkg::cordic_t  out_vec,
    output ppad_pkg::side_t    out_side
);
    import ppad_pkg::*;

    cordic_t vec_reg  [NSTAGE];
    side_t   side_reg [NSTAGE];
    logic    vld_reg  [NSTAGE];
    cordic_t vec_w    [NSTAGE+1];
    side_t   side_w   [NSTAGE+1];
    logic    vld_w    [NSTAGE+1];
    logic    rdy_w    [NSTAGE+1];

    assign vec_w[0]      = in_vec;
    assign side_w[0]     = in_side;
    assign vld_w[0]      = in_valid;
    assign rdy_w[NSTAGE] = out_ready;
    assign in_ready      = rdy_w[0];

    for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
        logic signed [XY_W-1:0] xin, yin, xs, ys;
        logic signed [Z_W-1:0]  zin;
        cordic_t                vec_next;

        // Rotate toward the x axis by atan(2^-k)
        assign xin = vec_w[k].x;
        assign yin = vec_w[k].y;
        assign zin = vec_w[k].z;
        assign xs  = xin >>> k;
        assign ys  = yin >>> k;

        always_comb begin
            if (!yin[XY_W-1]) begin
                vec_next.x = xin + ys;
                vec_next.y = yin - xs;
                vec_next.z = zin + ATAN_TAB[k];
            end else begin
                vec_next.x = xin - ys;
                vec_next.y = yin + xs;
                vec_next.z = zin - ATAN_TAB[k];
            end
        end

        assign rdy_w[k] = !vld_reg[k] || rdy_w[k+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (rdy_w[k]) begin
                vld_reg[k] <= vld_w[k];
            end
            if (rdy_w[k] && vld_w[k]) begin
                vec_reg[k]  <= vec_next;
                side_reg[k] <= side_w[k];
            end
        end

        assign vec_w[k+1]  = vec_reg[k];
        assign side_w[k+1] = side_reg[k];
        assign vld_w[k+1]  = vld_reg[k];
    end

    assign out_valid = vld_w[NSTAGE];
    assign out_vec   = vec_w[NSTAGE];
    assign out_side  = side_w[NSTAGE];

    `PPAD_ASSERT_IMP(a_x_positive, aclk, aresetn, out_valid && !out_side.special, out_vec.x > 0, "cordic: x went nonpositive during vectoring")
    `PPAD_ASSERT_IMP(a_z_span, aclk, aresetn, out_valid && !out_side.special, out_vec.z > -$signed(ATAN_TAB[0]), "cordic: accumulated angle out of span")
    `PPAD_ASSERT_NXT(a_last_hold, aclk, aresetn, out_valid && !out_ready, out_valid, "cordic: stalled result dropped")

endmodule

// File: rtl/ppad_finish.sv
// Output stage: clamp and round the CORDIC angle, add the quadrant base, register.
`include "point_pair_angle_degrees_core_assert.svh"
module ppad_finish (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ppad_pkg::cordic_t             in_vec,
    input  ppad_pkg::side_t               in_side,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ppad_pkg::ANGLE_W-1:0]  out_angle,
    output logic                          out_coin
);
    import ppad_pkg::*;

    logic [Z_W-1:0]     zc, zr;
    logic [AF_W-1:0]    q_round, q, sum;
    logic [ANGLE_W-1:0] angle_reg;
    logic               coin_reg, vld_reg;

    assign in_ready = !vld_reg || out_ready;

    // Clamp to [0, 90 degrees], round half up, clamp again, add base (special items take the base alone)
    always_comb begin
        if (in_vec.z[Z_W-1]) begin
            zc = '0;
        end else if (in_vec.z > $signed(Z_TOP)) begin
            zc = Z_TOP;
        end else begin
            zc = in_vec.z;
        end
        zr      = zc + Z_HALF;
        q_round = AF_W'(zr >> RND_SHIFT);
        q       = (q_round > DEG90_Q) ? DEG90_Q : q_round;
        sum     = in_side.special ? in_side.base : in_side.base + q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            angle_reg <= ANGLE_W'(sum);
            coin_reg  <= in_side.coin;
        end
    end

    assign out_valid = vld_reg;
    assign out_angle = angle_reg;
    assign out_coin  = coin_reg;

    `PPAD_ASSERT_IMP(a_coin_zero, aclk, aresetn, vld_reg && coin_reg, angle_reg == '0, "finish: coincident result with nonzero angle")
    `PPAD_ASSERT_IMP(a_sum_range, aclk, aresetn, in_valid && in_ready, sum <= DEG360_Q, "finish: angle above full turn")
    `PPAD_ASSERT_IMP(a_q_range, aclk, aresetn, in_valid && in_ready && !in_side.special, q <= DEG90_Q && (in_side.base == DEG0_Q || in_side.base == DEG90_Q || in_side.base == DEG180_Q || in_side.base == DEG270_Q), "finish: bad quadrant angle")

endmodule

// File: rtl/point_pair_angle_degrees_core.sv
// Top level: direction between two points in degrees, streaming CORDIC pipeline.
//
// Input channel (s_): one transaction carries a point pair, from (x, y) and
// to (x, y), signed, screen y growing downward. Output channel (m_): one
// transaction per input with the counterclockwise direction from the first
// point to the second in degrees times 128, 0 to 360 inclusive; a target
// straight to the right reads 360. Equal points set the coincident flag in
// m_tuser and give angle zero.
// The pipeline has two front stages for difference and quadrant decode,
// one register per CORDIC micro-rotation (16 micro-rotations) and one
// output stage for rounding and base add.
// Throughput is one transaction per cycle while m_tready stays high; every stage holds a valid bit and
// each micro-rotation has its own shift-add unit.
// When the receiver drops m_tready, the stalled result holds and the stages
// behind it keep filling their empty slots, so s_tready falls only once the
// pipeline is full. Nothing is dropped or repeated.
// Reset (aresetn low, synchronous) clears all valid bits; the data registers
// are not reset.
module point_pair_angle_degrees_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // from_x, from_y, to_x, to_y
    input  logic [ppad_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // angle_q7
    output logic [ppad_pkg::ANGLE_W-1:0]     m_tdata,
    // coincident
    output logic [0:0]                       m_tuser
);
    import ppad_pkg::*;

    logic    f_valid, f_ready, c_valid, c_ready;
    cordic_t f_vec, c_vec;
    side_t   f_side, c_side;
    logic    coin;

    // Differences and seed
    ppad_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_vec   (f_vec),
        .out_side  (f_side)
    );

    // Vectoring
    ppad_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_vec    (f_vec),
        .in_side   (f_side),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_vec   (c_vec),
        .out_side  (c_side)
    );

    // Round and add base
    ppad_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_vec    (c_vec),
        .in_side   (c_side),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_angle (m_tdata),
        .out_coin  (coin)
    );

    assign m_tuser = coin;

endmodule

// File: tb/point_pair_angle_degrees_core_tb.sv
// Testbench for the point pair angle core: random and directed pairs against a CORDIC predictor.
module point_pair_angle_degrees_core_tb;

    // Predictor formats
    localparam int     FRAC_BITS    = 7;
    localparam int     GUARD        = 8;
    localparam int     TAB_FRAC     = 24;
    localparam int     TAB_LEN      = 24;
    localparam int     ROT_COUNT    = (16 > TAB_LEN) ? TAB_LEN : 16;
    localparam int     ROUND_SHIFT  = TAB_FRAC - FRAC_BITS;
    localparam longint DEG90_Q      = 64'd90 << FRAC_BITS;
    localparam longint DEG180_Q     = 64'd180 << FRAC_BITS;
    localparam longint DEG270_Q     = 64'd270 << FRAC_BITS;
    localparam longint DEG360_Q     = 64'd360 << FRAC_BITS;
    localparam longint Z_TOP        = 64'd90 << TAB_FRAC;

    // Run control
    localparam int RANDOM_PAIRS  = 550;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AT       = 120;
    localparam int FULL_RATE_LO  = 350;
    localparam int FULL_RATE_HI  = 450;
    localparam int DRAIN_AT      = 200;
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 100;

    // atan(2^-i) in degrees scaled by 2^24
    localparam longint ROT_DEG_TAB [TAB_LEN] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    // Shapes of random point pairs
    typedef enum int {
        PAIR_ANY,
        PAIR_NEAR,
        PAIR_AXIS,
        PAIR_SAME
    } pair_kind_t;

    typedef struct {
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic               drain_first;
    } point_pair_t;

    typedef struct {
        logic [15:0] angle;
        logic        coincident;
    } direction_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ppad_pkg::IN_TDATA_W-1:0] s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ppad_pkg::ANGLE_W-1:0]    m_tdata;
    logic [0:0]                      m_tuser;

    point_pair_t pending_pairs [$];
    direction_t  expected_dirs [$];
    point_pair_t on_bus;
    direction_t  oldest_dir;

    int n_sent        = 0;
    int n_results     = 0;
    int n_coincident  = 0;
    int n_directed    = 0;
    int n_errors      = 0;
    int n_cycles      = 0;
    int burst_left    = 1;
    int gap_left      = 0;
    int hold_left     = 0;
    int run_left      = 0;
    bit long_hold_done = 1'b0;
    bit rx_ready      = 1'b0;
    bit launch;

    point_pair_angle_degrees_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // First-quadrant atan(num/den) in degrees * 128 by CORDIC vectoring
    function automatic longint quadrant_angle(longint den, longint num);
        longint x, y, z, xs, ys, q;
        x = den <<< GUARD;
        y = num <<< GUARD;
        z = 0;
        for (int i = 0; i < ROT_COUNT; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ROT_DEG_TAB[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ROT_DEG_TAB[i];
            end
        end
        if (z < 0) z = 0;
        if (z > Z_TOP) z = Z_TOP;
        q = (z + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        if (q > DEG90_Q) q = DEG90_Q;
        return q;
    endfunction

    // Direction from the first point to the second, screen y growing downward
    function automatic direction_t predict_direction(point_pair_t p);
        longint dx, dy, h, v, ang;
        direction_t r;
        dx = longint'(p.tx) - longint'(p.fx);
        dy = longint'(p.ty) - longint'(p.fy);
        h = (dx < 0) ? -dx : dx;
        v = (dy < 0) ? -dy : dy;
        r.coincident = 1'b0;
        if (dx == 0 && dy == 0) begin
            r.coincident = 1'b1;
            ang = 0;
        end else if (dy == 0) begin
            ang = (dx > 0) ? DEG360_Q : DEG180_Q;
        end else if (dx == 0) begin
            ang = (dy < 0) ? DEG90_Q : DEG270_Q;
        end else if (dx > 0 && dy < 0) begin
            ang = quadrant_angle(h, v);
        end else if (dx < 0 && dy < 0) begin
            ang = DEG90_Q + quadrant_angle(v, h);
        end else if (dx < 0) begin
            ang = DEG180_Q + quadrant_angle(h, v);
        end else begin
            ang = DEG270_Q + quadrant_angle(v, h);
        end
        r.angle = ang[15:0];
        return r;
    endfunction

    task automatic add_pair(int fx, int fy, int tx, int ty, bit drain);
        point_pair_t p;
        p.fx = 16'(fx);
        p.fy = 16'(fy);
        p.tx = 16'(tx);
        p.ty = 16'(ty);
        p.drain_first = drain;
        pending_pairs.push_back(p);
    endtask

    // Drive point pairs in bursts; hold a pair until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            launch = 1'b0;
            if (s_tvalid && s_tready) begin
                expected_dirs.push_back(predict_direction(on_bus));
                n_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_pairs.size() > 0 &&
                             (!pending_pairs[0].drain_first || expected_dirs.size() == 0)) begin
                    on_bus = pending_pairs.pop_front();
                    launch = 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = (n_sent >= FULL_RATE_LO && n_sent < FULL_RATE_HI) ?
                                   0 : $urandom_range(0, 7);
                    end
                end
                s_tvalid <= launch;
                if (launch)
                    s_tdata <= {on_bus.ty, on_bus.tx, on_bus.fy, on_bus.fx};
            end
        end
    end

    // Stall the result channel: one long hold-off, a full-rate stretch, random runs elsewhere
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!long_hold_done && n_results >= HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (n_results >= FULL_RATE_LO && n_results < FULL_RATE_HI) begin
            m_tready <= 1'b1;
        end else begin
            if (run_left == 0) begin
                rx_ready = !rx_ready;
                run_left = rx_ready ? $urandom_range(1, 12) : $urandom_range(1, 5);
            end
            run_left--;
            m_tready <= rx_ready;
        end
    end

    // Compare each result transaction with the oldest predicted direction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_dirs.size() == 0) begin
                n_errors++;
                if (n_errors <= REPORT_LIMIT)
                    $error("unexpected result: angle_q7 %0d coincident %0d", m_tdata, m_tuser[0]);
            end else begin
                oldest_dir = expected_dirs.pop_front();
                n_results++;
                if (oldest_dir.coincident) n_coincident++;
                if (m_tdata !== oldest_dir.angle) begin
                    n_errors++;
                    if (n_errors <= REPORT_LIMIT)
                        $error("angle_q7: expected %0d, actual %0d", oldest_dir.angle, m_tdata);
                end
                if (m_tuser[0] !== oldest_dir.coincident) begin
                    n_errors++;
                    if (n_errors <= REPORT_LIMIT)
                        $error("coincident: expected %0d, actual %0d",
                               oldest_dir.coincident, m_tuser[0]);
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int         fx, fy, tx, ty;
        pair_kind_t kind;

        // Directed: coincident, axis targets, quadrant extremes, near-axis slopes
        add_pair(0, 0, 0, 0, 1'b0);
        add_pair(-32768, -32768, -32768, -32768, 1'b0);
        add_pair(32767, 32767, 32767, 32767, 1'b0);
        add_pair(0, 0, 5, 0, 1'b0);
        add_pair(-32768, 100, 32767, 100, 1'b0);
        add_pair(32767, -5, -32768, -5, 1'b0);
        add_pair(0, 0, 0, -7, 1'b0);
        add_pair(0, 32767, 0, -32768, 1'b0);
        add_pair(0, -32768, 0, 32767, 1'b0);
        add_pair(-32768, 32767, 32767, -32768, 1'b0);
        add_pair(32767, 32767, -32768, -32768, 1'b0);
        add_pair(32767, -32768, -32768, 32767, 1'b0);
        add_pair(-32768, -32768, 32767, 32767, 1'b0);
        add_pair(-32768, 0, 32767, -1, 1'b0);
        add_pair(0, 32767, 1, -32768, 1'b0);
        add_pair(32767, 0, -32768, -1, 1'b0);
        add_pair(0, 32767, -1, -32768, 1'b0);
        add_pair(32767, 0, -32768, 1, 1'b0);
        add_pair(0, -32768, -1, 32767, 1'b0);
        add_pair(-32768, 0, 32767, 1, 1'b0);
        add_pair(0, -32768, 1, 32767, 1'b0);
        add_pair(10, 10, 11, 9, 1'b0);
        add_pair(100, -200, -300, 400, 1'b0);
        n_directed = pending_pairs.size();

        // Random: mostly full range and short vectors, some axis and coincident pairs
        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            fx = $urandom_range(0, 65535);
            fy = $urandom_range(0, 65535);
            tx = $urandom_range(0, 65535);
            ty = $urandom_range(0, 65535);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: kind = PAIR_ANY;
                5, 6, 7:       kind = PAIR_NEAR;
                8:             kind = PAIR_AXIS;
                default:       kind = PAIR_SAME;
            endcase
            case (kind)
                PAIR_NEAR: begin
                    tx = fx + $urandom_range(0, 16) - 8;
                    ty = fy + $urandom_range(0, 16) - 8;
                end
                PAIR_AXIS: begin
                    if ($urandom_range(0, 1)) tx = fx;
                    else ty = fy;
                end
                PAIR_SAME: begin
                    tx = fx;
                    ty = fy;
                end
                default: ;
            endcase
            add_pair(fx, fy, tx, ty, n_directed + i == DRAIN_AT);
        end

        // Hold reset, then release once
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every pair to be sent and every direction to come back
        while (pending_pairs.size() > 0 || s_tvalid || expected_dirs.size() > 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d point pairs (%0d directed), checked %0d directions, %0d coincident.",
                 n_sent, n_directed, n_results, n_coincident);
        $display("Run included a %0d-cycle output hold-off and a full drain pause.", LONG_HOLD);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
